// File: hdl/pst_pkg.sv
// -----------------------------------------------------------------------------
// Process slot table package
// Shared constants, codes and the command and status records that pass
// between the controller and the datapath.
// -----------------------------------------------------------------------------
package pst_pkg;

    localparam int SLOTS   = 64;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int FIELD_W = 7;
    localparam int TID_W   = 32;

    localparam logic [TID_W-1:0] IDLE_TID = TID_W'(1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_LOOKUP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_IDLE      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_SCAN,
        S_RD_SLOT,
        S_LK_RD,
        S_LK_CMP,
        S_DONE
    } t_state;

    // Which result the datapath stages for the current transaction.
    typedef enum logic [2:0] {
        RES_NONE,
        RES_FULL,
        RES_NOT_FOUND,
        RES_IDLE,
        RES_INSERT,
        RES_SLOT_READ,
        RES_LOOKUP
    } t_res;

    typedef struct packed {
        logic load;        // capture the accepted request
        logic ins_write;   // fill the hinted slot
        logic scan_start;  // start the lookup scan at slot zero
        logic idx_inc;     // advance the scan index with wrap
        logic hint_idx;    // hint takes the scan index
        logic rd_en;       // read the tid memory
        logic rd_slot;     // read address is the requested slot
        logic rem_commit;  // clear the requested slot
        t_res res;
        logic out_load;    // move the staged result to the output register
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic last_free;
        logic slot_ok;
        logic idle_tid;
        logic cur_empty;
        logic idx_last;
        logic match;
        logic out_free;
    } t_dp_sts;

endpackage

// File: hdl/pst_if.sv
// -----------------------------------------------------------------------------
// Process slot table channels
// Request and response channels with a valid and ready handshake.
// -----------------------------------------------------------------------------
interface pst_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   op;
    logic [pst_pkg::FIELD_W-1:0]  slot;
    logic [pst_pkg::TID_W-1:0]    tid;

    modport source (output valid, output op, output slot, output tid, input ready);
    modport sink   (input valid, input op, input slot, input tid, output ready);
endinterface

interface pst_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [pst_pkg::FIELD_W-1:0]  result_slot;
    logic [pst_pkg::TID_W-1:0]    result_tid;
    logic [pst_pkg::FIELD_W-1:0]  free_count;
    logic [pst_pkg::FIELD_W-1:0]  next_free;

    modport source (output valid, output status, output result_slot, output result_tid,
                    output free_count, output next_free, input ready);
    modport sink   (input valid, input status, input result_slot, input result_tid,
                    input free_count, input next_free, output ready);
endinterface

// File: hdl/pst_ctrl.sv
// -----------------------------------------------------------------------------
// Process slot table controller
// Sequences one transaction at a time through decode, scans and reads.
// -----------------------------------------------------------------------------
module pst_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pst_pkg::t_dp_sts i_sts,
    output pst_pkg::t_dp_cmd o_cmd
);

    pst_pkg::t_state r_state;
    pst_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pst_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pst_pkg::S_IDLE: begin
                if (i_in_valid) n_state = pst_pkg::S_DECODE;
            end
            pst_pkg::S_DECODE: begin
                case (i_sts.op)
                    pst_pkg::OP_INSERT: begin
                        if (i_sts.full || i_sts.last_free) n_state = pst_pkg::S_DONE;
                        else n_state = pst_pkg::S_INS_SCAN;
                    end
                    pst_pkg::OP_FIND, pst_pkg::OP_REMOVE: begin
                        if (i_sts.slot_ok) n_state = pst_pkg::S_RD_SLOT;
                        else n_state = pst_pkg::S_DONE;
                    end
                    default: begin
                        if (i_sts.idle_tid) n_state = pst_pkg::S_DONE;
                        else n_state = pst_pkg::S_LK_RD;
                    end
                endcase
            end
            pst_pkg::S_INS_SCAN: begin
                if (i_sts.cur_empty) n_state = pst_pkg::S_DONE;
            end
            pst_pkg::S_RD_SLOT: n_state = pst_pkg::S_DONE;
            pst_pkg::S_LK_RD:   n_state = pst_pkg::S_LK_CMP;
            pst_pkg::S_LK_CMP: begin
                if (i_sts.match || i_sts.idx_last) n_state = pst_pkg::S_DONE;
                else n_state = pst_pkg::S_LK_RD;
            end
            pst_pkg::S_DONE: begin
                if (i_sts.out_free) n_state = pst_pkg::S_IDLE;
            end
            default: n_state = pst_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.res  = pst_pkg::RES_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            pst_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            pst_pkg::S_DECODE: begin
                case (i_sts.op)
                    pst_pkg::OP_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.res = pst_pkg::RES_FULL;
                        end else begin
                            o_cmd.ins_write = 1'b1;
                            o_cmd.res       = pst_pkg::RES_INSERT;
                        end
                    end
                    pst_pkg::OP_FIND, pst_pkg::OP_REMOVE: begin
                        if (i_sts.slot_ok) begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_slot = 1'b1;
                        end else begin
                            o_cmd.res = pst_pkg::RES_NOT_FOUND;
                        end
                    end
                    default: begin
                        if (i_sts.idle_tid) o_cmd.res = pst_pkg::RES_IDLE;
                        else o_cmd.scan_start = 1'b1;
                    end
                endcase
            end
            pst_pkg::S_INS_SCAN: begin
                if (i_sts.cur_empty) o_cmd.hint_idx = 1'b1;
                else o_cmd.idx_inc = 1'b1;
            end
            pst_pkg::S_RD_SLOT: begin
                o_cmd.res        = pst_pkg::RES_SLOT_READ;
                o_cmd.rem_commit = (i_sts.op == pst_pkg::OP_REMOVE);
            end
            pst_pkg::S_LK_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            pst_pkg::S_LK_CMP: begin
                if (i_sts.match) begin
                    o_cmd.res = pst_pkg::RES_LOOKUP;
                end else if (i_sts.idx_last) begin
                    o_cmd.res = pst_pkg::RES_NOT_FOUND;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            pst_pkg::S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/pst_dp.sv
// -----------------------------------------------------------------------------
// Process slot table datapath
// Valid marks, tid memory, free count, next-free hint, scan index, result
// staging and the output register.
// -----------------------------------------------------------------------------
module pst_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pst_pkg::t_dp_cmd             i_cmd,
    output pst_pkg::t_dp_sts             o_sts,
    input  logic [1:0]                   i_op,
    input  logic [pst_pkg::FIELD_W-1:0]  i_slot,
    input  logic [pst_pkg::TID_W-1:0]    i_tid,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [1:0]                   o_status,
    output logic [pst_pkg::FIELD_W-1:0]  o_result_slot,
    output logic [pst_pkg::TID_W-1:0]    o_result_tid,
    output logic [pst_pkg::FIELD_W-1:0]  o_free_count,
    output logic [pst_pkg::FIELD_W-1:0]  o_next_free
);

    localparam logic [pst_pkg::FIELD_W-1:0] SLOTS_F = pst_pkg::FIELD_W'(pst_pkg::SLOTS);
    localparam logic [pst_pkg::IDX_W-1:0]   LAST_IDX = pst_pkg::IDX_W'(pst_pkg::SLOTS - 1);

    logic [pst_pkg::SLOTS-1:0]   r_valid;
    logic [pst_pkg::TID_W-1:0]   r_mem [pst_pkg::SLOTS];
    logic [pst_pkg::TID_W-1:0]   r_rd_data;
    logic [pst_pkg::FIELD_W-1:0] r_count;
    logic [pst_pkg::FIELD_W-1:0] r_hint;
    logic [pst_pkg::IDX_W-1:0]   r_idx;

    pst_pkg::t_op                r_op;
    logic [pst_pkg::FIELD_W-1:0] r_slot;
    logic [pst_pkg::TID_W-1:0]   r_tid;

    pst_pkg::t_status            r_res_status;
    logic [pst_pkg::FIELD_W-1:0] r_res_slot;
    logic [pst_pkg::TID_W-1:0]   r_res_tid;

    logic                        r_out_valid;
    pst_pkg::t_status            r_out_status;
    logic [pst_pkg::FIELD_W-1:0] r_out_slot;
    logic [pst_pkg::TID_W-1:0]   r_out_tid;
    logic [pst_pkg::FIELD_W-1:0] r_out_count;
    logic [pst_pkg::FIELD_W-1:0] r_out_hint;

    logic [pst_pkg::IDX_W-1:0]   w_hint_idx;
    logic [pst_pkg::IDX_W-1:0]   w_slot_idx;
    logic [pst_pkg::IDX_W-1:0]   w_hint_next;
    logic [pst_pkg::IDX_W-1:0]   w_idx_next;
    logic [pst_pkg::IDX_W-1:0]   w_rd_addr;

    assign w_hint_idx  = r_hint[pst_pkg::IDX_W-1:0];
    assign w_slot_idx  = r_slot[pst_pkg::IDX_W-1:0];
    assign w_hint_next = (w_hint_idx == LAST_IDX) ? '0 : w_hint_idx + 1'b1;
    assign w_idx_next  = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
    assign w_rd_addr   = i_cmd.rd_slot ? w_slot_idx : r_idx;

    always_comb begin
        o_sts.op        = r_op;
        o_sts.full      = (r_count == '0) || (r_hint >= SLOTS_F);
        o_sts.last_free = (r_count == pst_pkg::FIELD_W'(1));
        o_sts.slot_ok   = (r_slot < SLOTS_F) && r_valid[w_slot_idx];
        o_sts.idle_tid  = (r_tid == pst_pkg::IDLE_TID);
        o_sts.cur_empty = !r_valid[r_idx];
        o_sts.idx_last  = (r_idx == LAST_IDX);
        o_sts.match     = r_valid[r_idx] && (r_rd_data == r_tid);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    // Tid memory: one write port for inserts, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_write) r_mem[w_hint_idx] <= r_tid;
        if (i_cmd.rd_en) r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= SLOTS_F;
            r_hint  <= '0;
        end else begin
            if (i_cmd.ins_write) begin
                r_valid[w_hint_idx] <= 1'b1;
                r_count             <= r_count - 1'b1;
                // No hint until the forward scan finds an empty slot or a remove frees one.
                r_hint              <= SLOTS_F;
            end
            if (i_cmd.hint_idx) begin
                r_hint <= {1'b0, r_idx};
            end
            if (i_cmd.rem_commit) begin
                r_valid[w_slot_idx] <= 1'b0;
                r_count             <= r_count + 1'b1;
                r_hint              <= r_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= pst_pkg::t_op'(i_op);
            r_slot <= i_slot;
            r_tid  <= i_tid;
        end
        if (i_cmd.ins_write) begin
            r_idx <= w_hint_next;
        end else if (i_cmd.scan_start) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= w_idx_next;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.res)
            pst_pkg::RES_FULL: begin
                r_res_status <= pst_pkg::ST_FULL;
                r_res_slot   <= '0;
                r_res_tid    <= '0;
            end
            pst_pkg::RES_NOT_FOUND: begin
                r_res_status <= pst_pkg::ST_NOT_FOUND;
                r_res_slot   <= '0;
                r_res_tid    <= '0;
            end
            pst_pkg::RES_IDLE: begin
                r_res_status <= pst_pkg::ST_IDLE;
                r_res_slot   <= SLOTS_F;
                r_res_tid    <= '0;
            end
            pst_pkg::RES_INSERT: begin
                r_res_status <= pst_pkg::ST_OK;
                r_res_slot   <= r_hint;
                r_res_tid    <= r_tid;
            end
            pst_pkg::RES_SLOT_READ: begin
                r_res_status <= pst_pkg::ST_OK;
                r_res_slot   <= r_slot;
                r_res_tid    <= r_rd_data;
            end
            pst_pkg::RES_LOOKUP: begin
                r_res_status <= pst_pkg::ST_OK;
                r_res_slot   <= {1'b0, r_idx};
                r_res_tid    <= r_tid;
            end
            default: begin
                r_res_status <= r_res_status;
            end
        endcase
    end

    // Output register: holds a finished result while a new request is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_tid    <= r_res_tid;
            r_out_count  <= r_count;
            r_out_hint   <= r_hint;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_result_slot = r_out_slot;
    assign o_result_tid  = r_out_tid;
    assign o_free_count  = r_out_count;
    assign o_next_free   = r_out_hint;

`ifndef SYNTH
    // The free count always agrees with the number of empty slots.
    a_count_matches_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_valid) + int'(r_count)) == pst_pkg::SLOTS)
        else $error("free count disagrees with valid marks");

    // A hint that names a slot always names an empty one.
    a_hint_points_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hint < SLOTS_F) |-> !r_valid[w_hint_idx])
        else $error("next-free hint names an occupied slot");

    // A full report is only given when no slot is empty and no hint exists.
    a_full_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == pst_pkg::ST_FULL)
            |-> (r_out_count == '0 && r_out_hint == SLOTS_F))
        else $error("table full reported with empty slots left");
`endif

endmodule

// File: hdl/process_slot_table_unit.sv
// -----------------------------------------------------------------------------
// Process slot table unit
// Slot allocator with a next-free hint and a tid search, one transaction at
// a time.
// -----------------------------------------------------------------------------
// A request is taken whenever the unit is idle, even while the previous
// result still waits in the output register. Find and remove read the
// requested slot, and a full insert or an idle-thread lookup ends at decode.
// An insert that leaves free slots then scans the valid marks forward one
// slot a cycle to the next empty slot. A tid lookup reads the tid memory
// one slot at a time from slot zero through its single registered read port,
// reads and then compares each slot, and stops at a match or the last slot.
module process_slot_table_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pst_req_if.sink   i_req,
    pst_rsp_if.source o_rsp
);

    pst_pkg::t_dp_cmd w_cmd;
    pst_pkg::t_dp_sts w_sts;
    logic             w_in_ready;

    assign i_req.ready = w_in_ready;

    pst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pst_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_op          (i_req.op),
        .i_slot        (i_req.slot),
        .i_tid         (i_req.tid),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_result_slot (o_rsp.result_slot),
        .o_result_tid  (o_rsp.result_tid),
        .o_free_count  (o_rsp.free_count),
        .o_next_free   (o_rsp.next_free)
    );

endmodule
